// ===== design/gcme_pkg.sv =====
// Package for the GOST block cipher mode engine: modes, register indexes,
// controller/datapath command and status types, S-box substitution.
// No dependencies.
package gcme_pkg;

	localparam int BLK_W    = 64;
	localparam int HALF_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int ROUND_W  = 5;
	localparam int ROT_LEFT = 11;

	localparam logic [ROUND_W-1:0] LAST_ROUND_FULL = 5'd31;
	localparam logic [ROUND_W-1:0] LAST_ROUND_MAC  = 5'd15;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IV    = 3'd6;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_OFB = 2'd1,
		MODE_CFB = 2'd2,
		MODE_MAC = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       load;
		logic       round;
		logic [2:0] key_idx;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  dir;
		logic  out_busy;
	} sts_t;

	localparam logic [3:0] SBOX [0:7][0:15] = '{
		'{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
		  4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
		'{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
		  4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
		'{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
		  4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
		'{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
		  4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
		'{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
		  4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
		'{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
		  4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
		'{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
		  4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
		'{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
		  4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
	};

	// Nibble i goes through box i
	function automatic logic [HALF_W-1:0] sbox_sub(input logic [HALF_W-1:0] s);
		logic [HALF_W-1:0] t;
		t = '0;
		for (int i = 0; i < 8; i++) begin
			t[4*i +: 4] = SBOX[i][s[4*i +: 4]];
		end
		return t;
	endfunction

endpackage

// ===== design/gcme_if.sv =====
// Channel interfaces of the GOST cipher mode engine: input items, results,
// configuration writes. Depends on gcme_pkg.
interface gcme_in_if import gcme_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] block_in;
	logic             restart;

	modport source (output valid, output block_in, output restart, input ready);
	modport sink   (input valid, input block_in, input restart, output ready);
endinterface

interface gcme_out_if import gcme_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] block_out;

	modport source (output valid, output block_out, input ready);
	modport sink   (input valid, input block_out, output ready);
endinterface

interface gcme_cfg_if import gcme_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BLK_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/gcme_ctrl.sv =====
// Controller of the GOST cipher mode engine: sequences load, rounds and finish,
// chooses the subkey order. Depends on gcme_pkg.
module gcme_ctrl import gcme_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t             state_q, state_d;
	logic [ROUND_W-1:0] round_q;
	logic               last_round;
	logic               reverse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.round) begin
				round_q <= last_round ? '0 : round_q + 1'b1;
			end
		end
	end

	assign last_round = (sts.mode == MODE_MAC) ? (round_q == LAST_ROUND_MAC)
	                                           : (round_q == LAST_ROUND_FULL);

	// Encrypt: 0..7 three times then 7..0; decrypt: 0..7 then 7..0 three times; MAC: 0..7 twice
	always_comb begin
		unique case (sts.mode)
			MODE_ECB: reverse = sts.dir ? (round_q[4:3] != 2'd0) : (round_q[4:3] == 2'd3);
			MODE_OFB,
			MODE_CFB: reverse = (round_q[4:3] == 2'd3);
			default:  reverse = 1'b0;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		cmd.load    = 1'b0;
		cmd.round   = 1'b0;
		cmd.finish  = 1'b0;
		cmd.key_idx = reverse ? ~round_q[2:0] : round_q[2:0];
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.round = 1'b1;
				if (last_round) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN))
		else $error("load did not start the round sequence");
	a_idle_round_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (round_q == '0))
		else $error("round counter not cleared while idle");
	a_finish_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_busy)
		else $error("finish while output register still held");
	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_IDLE))
		else $error("finish did not return to idle");
`endif

endmodule

// ===== design/gcme_datapath.sv =====
// Datapath of the GOST cipher mode engine: configuration registers, feedback,
// round unit, result register. Depends on gcme_pkg and gcme_if.
module gcme_datapath import gcme_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [BLK_W-1:0] block_in,
	input  logic             restart,
	gcme_cfg_if.sink         cfg,
	gcme_out_if.source       result,
	input  cmd_t             cmd,
	output sts_t             sts
);

	logic [BLK_W-1:0]  key_q [0:3];
	mode_t             mode_q;
	logic              dir_q;
	logic [BLK_W-1:0]  iv_q;
	logic [BLK_W-1:0]  fb_q;
	logic [BLK_W-1:0]  blk_q;
	logic [HALF_W-1:0] n1_q, n2_q;
	logic [BLK_W-1:0]  res_q;
	logic              out_valid_q;

	logic [BLK_W-1:0]  fb_start;
	logic [BLK_W-1:0]  src;
	logic [BLK_W-1:0]  key_word;
	logic [HALF_W-1:0] subkey, sum, sub, rot;
	logic [BLK_W-1:0]  gamma;
	logic [BLK_W-1:0]  xored;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			mode_q <= MODE_ECB;
			dir_q  <= 1'b0;
			iv_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KEY_A: key_q[0] <= cfg.data;
				REG_KEY_B: key_q[1] <= cfg.data;
				REG_KEY_C: key_q[2] <= cfg.data;
				REG_KEY_D: key_q[3] <= cfg.data;
				REG_MODE:  mode_q   <= mode_t'(cfg.data[1:0]);
				REG_DIR:   dir_q    <= cfg.data[0];
				REG_IV:    iv_q     <= cfg.data;
				default:   ;
			endcase
		end
	end

	// Starting halves per mode; outside ECB, restart reloads the feedback first
	always_comb begin
		unique case (mode_q)
			MODE_ECB: fb_start = fb_q;
			MODE_MAC: fb_start = restart ? '0 : fb_q;
			default:  fb_start = restart ? iv_q : fb_q;
		endcase
		unique case (mode_q)
			MODE_ECB: src = block_in;
			MODE_MAC: src = fb_start ^ block_in;
			default:  src = fb_start;
		endcase
	end

	assign key_word = key_q[cmd.key_idx[2:1]];
	assign subkey   = cmd.key_idx[0] ? key_word[BLK_W-1:HALF_W] : key_word[HALF_W-1:0];
	assign sum      = n1_q + subkey;
	assign sub      = sbox_sub(sum);
	assign rot      = {sub[HALF_W-1-ROT_LEFT:0], sub[HALF_W-1:HALF_W-ROT_LEFT]};
	assign gamma    = {n1_q, n2_q};
	assign xored    = blk_q ^ gamma;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n1_q  <= src[HALF_W-1:0];
			n2_q  <= src[BLK_W-1:HALF_W];
			blk_q <= block_in;
		end else if (cmd.round) begin
			n1_q <= n2_q ^ rot;
			n2_q <= n1_q;
		end
		if (cmd.finish) begin
			unique case (mode_q)
				MODE_ECB: res_q <= gamma;
				MODE_MAC: res_q <= gamma;
				default:  res_q <= xored;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				unique case (mode_q)
					MODE_ECB: fb_q <= fb_q;
					MODE_CFB: fb_q <= dir_q ? blk_q : xored;
					default:  fb_q <= gamma;
				endcase
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.block_out = res_q;

	assign sts.mode     = mode_q;
	assign sts.dir      = dir_q;
	assign sts.out_busy = out_valid_q && !result.ready;

endmodule

// ===== design/gost_cipher_mode_engine.sv =====
// Top level of the GOST 28147-89 cipher mode engine (ECB, OFB, CFB, MAC).
// Depends on gcme_pkg, gcme_if, gcme_ctrl and gcme_datapath.
//
// Usage:
//   cfg    - write channel; index selects key_words_a..d (0..3), cipher_mode (4),
//            direction (5), init_vector (6). Other indexes are dropped. Ready is
//            always high. Write only while no block is in flight.
//   item   - one 64-bit block per transaction plus the restart flag, which
//            reloads the feedback (init vector in OFB/CFB, zero in MAC).
//   result - one 64-bit block per item transaction; in MAC the tag is bits 31:0.
// Timing: one shared round unit runs one round per cycle. An item goes
//   through a load step, 32 rounds (16 in MAC) and a finish step that
//   registers its result; the next item is taken only after that finish
//   step. Outside ECB, each block chains off the feedback left by the one
//   before it.
// Stall: the result sits in an output register; the next item is taken while
//   it waits, and its rounds run, but the finish step holds until the
//   waiting result is taken.
// Reset: arst_n clears keys, mode, direction, init vector and feedback to zero
//   and drops any block in flight.
module gost_cipher_mode_engine import gcme_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	gcme_cfg_if.sink    cfg,
	gcme_in_if.sink     item,
	gcme_out_if.source  result
);

	cmd_t cmd;
	sts_t sts;

	// Sequence load, rounds and finish
	gcme_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Hold configuration and feedback, run the round unit, drive the result
	gcme_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.block_in (item.block_in),
		.restart  (item.restart),
		.cfg      (cfg),
		.result   (result),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for gost_cipher_mode_engine: directed and random blocks
// through all four chaining modes, checked against an in-bench cipher model.
// Depends on gcme_pkg, the gcme channel interfaces and the engine RTL.
module testbench;
	import gcme_pkg::*;

	// Index with no register behind it; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned MAX_WAIT  = 19;
	localparam int unsigned DRAIN_CYC = 40;
	localparam int unsigned RND_PHASES = 12;
	localparam int unsigned RND_BLOCKS = 150;

	// Fixed substitution boxes, nibble i goes through row i
	localparam logic [3:0] SUBST [0:7][0:15] = '{
		'{4, 10, 9, 2, 13, 8, 0, 14, 6, 11, 1, 12, 7, 15, 5, 3},
		'{14, 11, 4, 12, 6, 13, 15, 10, 2, 3, 8, 1, 0, 7, 5, 9},
		'{5, 8, 1, 13, 10, 3, 4, 2, 14, 15, 12, 7, 6, 0, 9, 11},
		'{7, 13, 10, 1, 0, 8, 9, 15, 14, 4, 6, 12, 11, 2, 5, 3},
		'{6, 12, 7, 1, 5, 15, 13, 8, 4, 10, 9, 14, 0, 3, 11, 2},
		'{4, 11, 10, 0, 7, 2, 1, 13, 3, 6, 8, 5, 9, 12, 15, 14},
		'{13, 11, 4, 1, 3, 15, 5, 9, 0, 10, 14, 7, 6, 8, 2, 12},
		'{1, 15, 13, 0, 5, 7, 10, 4, 9, 2, 3, 14, 6, 11, 8, 12}
	};

	typedef enum logic [1:0] {
		PASS_ENC,
		PASS_DEC,
		PASS_MAC
	} pass_kind_t;

	// One entry of the stimulus script: a register write or a data block
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] index;
		logic [BLK_W-1:0]     data;
		logic                 restart;
	} pending_op_t;

	typedef struct {
		int unsigned      seq;
		logic [BLK_W-1:0] block_out;
	} expected_block_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	gcme_cfg_if cfg_ch ();
	gcme_in_if  item_ch ();
	gcme_out_if result_ch ();

	gost_cipher_mode_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pending_op_t     pending_ops [$];
	expected_block_t expected_blocks [$];

	// Bench copy of the engine's registers and chaining state
	logic [BLK_W-1:0] key_regs [0:3];
	mode_t            mode_q;
	logic             dir_q;
	logic [BLK_W-1:0] iv_q;
	logic [BLK_W-1:0] chain_q;

	int unsigned n_sent;
	int unsigned n_recv;
	int unsigned err_count = 0;
	int unsigned gap_left;
	int unsigned stall_left;
	bit          send_quiet = 1'b0;
	bit          recv_quiet = 1'b0;

	task automatic note_failure(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic logic [HALF_W-1:0] round_mix(input logic [HALF_W-1:0] n1,
		input logic [HALF_W-1:0] k);
		logic [HALF_W-1:0] s;
		logic [HALF_W-1:0] t;
		s = n1 + k;
		for (int i = 0; i < 8; i++) begin
			t[4*i +: 4] = SUBST[i][s[4*i +: 4]];
		end
		return {t[HALF_W-12:0], t[HALF_W-1 -: 11]};
	endfunction

	// Run the 32-round (or 16-round MAC) transform on one block
	function automatic logic [BLK_W-1:0] gost_crypt(input logic [BLK_W-1:0] blk,
		input pass_kind_t kind);
		logic [HALF_W-1:0] n1;
		logic [HALF_W-1:0] n2;
		logic [HALF_W-1:0] mixed;
		logic [2:0]        ki;
		int                total;
		n1 = blk[HALF_W-1:0];
		n2 = blk[BLK_W-1:HALF_W];
		total = (kind == PASS_MAC) ? 16 : 32;
		for (int r = 0; r < total; r++) begin
			ki = r[2:0];
			if ((kind == PASS_ENC && r >= 24) || (kind == PASS_DEC && r >= 8))
				ki = 3'd7 - ki;
			mixed = n2 ^ round_mix(n1, key_regs[ki[2:1]][HALF_W*ki[0] +: HALF_W]);
			n2 = n1;
			n1 = mixed;
		end
		return {n1, n2};
	endfunction

	// Predict block_out for one accepted block and advance the chaining state
	function automatic logic [BLK_W-1:0] cipher_step(input logic [BLK_W-1:0] blk,
		input logic restart);
		logic [BLK_W-1:0] gamma;
		logic [BLK_W-1:0] res;
		case (mode_q)
			MODE_ECB: begin
				res = gost_crypt(blk, dir_q ? PASS_DEC : PASS_ENC);
			end
			MODE_OFB: begin
				if (restart)
					chain_q = iv_q;
				gamma = gost_crypt(chain_q, PASS_ENC);
				res = blk ^ gamma;
				chain_q = gamma;
			end
			MODE_CFB: begin
				if (restart)
					chain_q = iv_q;
				gamma = gost_crypt(chain_q, PASS_ENC);
				res = blk ^ gamma;
				chain_q = dir_q ? blk : res;
			end
			default: begin
				if (restart)
					chain_q = '0;
				chain_q = gost_crypt(chain_q ^ blk, PASS_MAC);
				res = chain_q;
			end
		endcase
		return res;
	endfunction

	function automatic void apply_config(input logic [CFG_IDX_W-1:0] index,
		input logic [BLK_W-1:0] data);
		case (index)
			REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D: key_regs[index[1:0]] = data;
			REG_MODE: mode_q = mode_t'(data[1:0]);
			REG_DIR:  dir_q = data[0];
			REG_IV:   iv_q = data;
			default: ;
		endcase
	endfunction

	function automatic int unsigned draw_wait(input bit quiet);
		return quiet ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [BLK_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random value, leaning on the all-zero and all-one extremes now and then
	function automatic logic [BLK_W-1:0] pick64();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return rand64();
		endcase
	endfunction

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] index, input logic [BLK_W-1:0] data);
		pending_op_t op;
		op = '{1'b1, index, data, 1'b0};
		pending_ops = {pending_ops, op};
	endtask

	task automatic push_block(input logic [BLK_W-1:0] data, input logic restart);
		pending_op_t op;
		op = '{1'b0, '0, data, restart};
		pending_ops = {pending_ops, op};
	endtask

	// Driver: present the script one transaction at a time. Register writes
	// hold off until every block sent so far has come back, so the engine is
	// idle when its configuration changes. Blocks wait out a random gap.
	always @(posedge clk or negedge arst_n) begin : drive_ops
		pending_op_t     op;
		expected_block_t exp_entry;
		int unsigned     gap;
		logic            blk_done;
		logic            cfg_done;
		logic            item_hold;
		logic            cfg_hold;
		if (!arst_n) begin
			item_ch.valid    <= 1'b0;
			item_ch.block_in <= '0;
			item_ch.restart  <= 1'b0;
			cfg_ch.valid     <= 1'b0;
			cfg_ch.index     <= '0;
			cfg_ch.data      <= '0;
			gap_left         <= 0;
			n_sent           <= 0;
			for (int i = 0; i < 4; i++)
				key_regs[i] = '0;
			mode_q  = MODE_ECB;
			dir_q   = 1'b0;
			iv_q    = '0;
			chain_q = '0;
		end else begin
			blk_done = item_ch.valid && item_ch.ready;
			cfg_done = cfg_ch.valid && cfg_ch.ready;
			gap = gap_left;
			if (blk_done) begin
				// Predict on acceptance, in transaction order
				exp_entry = '{n_sent, cipher_step(item_ch.block_in, item_ch.restart)};
				expected_blocks = {expected_blocks, exp_entry};
				n_sent <= n_sent + 1;
				// Switch now and then between random gaps and back-to-back traffic
				if ($urandom_range(0, 31) == 0)
					send_quiet = !send_quiet;
				gap = draw_wait(send_quiet);
			end
			if (cfg_done)
				apply_config(cfg_ch.index, cfg_ch.data);
			item_hold = item_ch.valid && !blk_done;
			cfg_hold  = cfg_ch.valid && !cfg_done;
			if (!item_hold && !cfg_hold && pending_ops.size() != 0) begin
				op = pending_ops[0];
				if (op.is_cfg) begin
					// Both counters are last cycle's values: write once all results are home
					if (!blk_done && n_sent == n_recv) begin
						void'(pending_ops.pop_front());
						cfg_hold = 1'b1;
						cfg_ch.index <= op.index;
						cfg_ch.data  <= op.data;
					end
				end else if (gap != 0) begin
					gap--;
				end else begin
					void'(pending_ops.pop_front());
					item_hold = 1'b1;
					item_ch.block_in <= op.data;
					item_ch.restart  <= op.restart;
				end
			end
			item_ch.valid <= item_hold;
			cfg_ch.valid  <= cfg_hold;
			gap_left      <= gap;
		end
	end

	// Monitor: take results with random stalls and compare each with the
	// oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_results
		expected_block_t want;
		int unsigned     stall;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left      <= 0;
			n_recv          <= 0;
		end else begin
			stall = stall_left;
			if (result_ch.valid && result_ch.ready) begin
				if (expected_blocks.size() == 0) begin
					note_failure($sformatf("result %h with no block outstanding",
						result_ch.block_out));
				end else begin
					want = expected_blocks.pop_front();
					if (result_ch.block_out !== want.block_out)
						note_failure($sformatf("block %0d: block_out %h, want %h",
							want.seq, result_ch.block_out, want.block_out));
				end
				n_recv <= n_recv + 1;
				if ($urandom_range(0, 31) == 0)
					recv_quiet = !recv_quiet;
				stall = draw_wait(recv_quiet);
			end
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
			end
			stall_left <= stall;
		end
	end

	// Script: fill the queue up front, release reset, wait for the engine
	// to drain and report
	initial begin : run_script
		int unsigned p;
		int unsigned k;

		// ECB encrypt, zero key; stray upper bits in mode and direction are dropped,
		// an unused index is ignored, and restart has no effect in ECB
		push_cfg(REG_KEY_A, '0);
		push_cfg(REG_KEY_B, '0);
		push_cfg(REG_KEY_C, '0);
		push_cfg(REG_KEY_D, '0);
		push_cfg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFC);
		push_cfg(REG_DIR, 64'hFFFF_FFFF_FFFF_FFFE);
		push_cfg(REG_IV, '0);
		push_cfg(REG_UNUSED, '1);
		push_block('0, 1'b0);
		push_block('1, 1'b1);

		// ECB decrypt with an all-ones key
		push_cfg(REG_KEY_A, '1);
		push_cfg(REG_KEY_B, '1);
		push_cfg(REG_KEY_C, '1);
		push_cfg(REG_KEY_D, '1);
		push_cfg(REG_DIR, 64'd1);
		push_block('0, 1'b0);
		push_block('1, 1'b0);
		push_block(64'h0123_4567_89AB_CDEF, 1'b1);

		// OFB from an all-ones IV; direction is ignored here
		push_cfg(REG_KEY_A, 64'h0123_4567_89AB_CDEF);
		push_cfg(REG_KEY_B, 64'hFEDC_BA98_7654_3210);
		push_cfg(REG_KEY_C, 64'hA5A5_5A5A_0F0F_F0F0);
		push_cfg(REG_KEY_D, 64'h8000_0001_7FFF_FFFE);
		push_cfg(REG_MODE, 64'(MODE_OFB));
		push_cfg(REG_IV, '1);
		push_block(64'h1111_2222_3333_4444, 1'b1);
		push_block('0, 1'b0);
		push_block('1, 1'b0);
		push_block(64'hDEAD_BEEF_CAFE_F00D, 1'b1);

		// CFB encrypt, picking up the OFB feedback with no restart
		push_cfg(REG_MODE, 64'(MODE_CFB));
		push_cfg(REG_DIR, '0);
		push_block(64'h0F1E_2D3C_4B5A_6978, 1'b0);
		push_block('1, 1'b0);
		push_block('0, 1'b1);

		// CFB decrypt
		push_cfg(REG_DIR, '1);
		push_block(64'h8765_4321_0FED_CBA9, 1'b1);
		push_block('0, 1'b0);
		push_block('1, 1'b0);

		// MAC chain and restart; direction still set and ignored
		push_cfg(REG_MODE, '1);
		push_block(64'h0102_0304_0506_0708, 1'b1);
		push_block('1, 1'b0);
		push_block('0, 1'b0);
		push_block(64'h0102_0304_0506_0708, 1'b1);

		// OFB again, chaining straight off the MAC value
		push_cfg(REG_MODE, 64'(MODE_OFB));
		push_block('0, 1'b0);
		push_block(64'h5555_AAAA_5555_AAAA, 1'b0);

		// Random phases: fresh settings, then a long chain that usually starts with
		// a restart and only rarely restarts again midway
		for (p = 0; p < RND_PHASES; p++) begin
			for (k = 0; k < 7; k++) begin
				if ($urandom_range(0, 3) != 0)
					push_cfg(CFG_IDX_W'(k),
						(k == REG_MODE || k == REG_DIR) ? rand64() : pick64());
			end
			if ($urandom_range(0, 3) == 0)
				push_cfg(REG_UNUSED, rand64());
			for (k = 0; k < RND_BLOCKS; k++)
				push_block(pick64(), (k == 0) ? ($urandom_range(0, 3) != 0)
					: ($urandom_range(0, 15) == 0));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Sample on the falling edge, clear of the clocked processes
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || item_ch.valid || cfg_ch.valid || n_sent != n_recv);
		repeat (DRAIN_CYC) @(negedge clk);

		if (expected_blocks.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_blocks.size()));
		if (err_count == 0) begin
			$display("** gost_cipher_mode_engine: PASSED **");
		end else begin
			$display("** gost_cipher_mode_engine: FAILED **");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin : watchdog
		#8_000_000;
		$display("** gost_cipher_mode_engine: FAILED **");
		$finish;
	end

endmodule
